[src/str_pkg.sv]
// ----------------------------------------------------------------------------
// str_pkg: shared types and constants for the stepper trapezoid ramp unit
// Holds field widths, command and phase codes, and the request and result
// structures passed between the top level and the ramp core.
// ----------------------------------------------------------------------------
package str_pkg;

	// Field widths.
	localparam int CMD_W   = 2;
	localparam int LEVEL_W = 4;
	localparam int COUNT_W = 32;
	localparam int STEP_W  = 16;
	localparam int PHASE_W = 2;

	// Number of entries in the speed table.
	localparam int SPEED_LEVELS = 16;

	// Highest level a start may set; the target field cannot exceed its width.
	localparam int LEVEL_CAP = (SPEED_LEVELS - 1 > (1 << LEVEL_W) - 1)
		? (1 << LEVEL_W) - 1 : SPEED_LEVELS - 1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_CAP[LEVEL_W-1:0];

	// Reset value of the reload step register.
	localparam logic [STEP_W-1:0] RELOAD_STEP_RST = 16'd2500;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_PULSE = 2'd3
	} cmd_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_CRUISE = 2'd0,
		PH_ACCEL  = 2'd1,
		PH_DECEL  = 2'd2
	} phase_t;

	typedef struct packed {
		cmd_t                command;
		logic [LEVEL_W-1:0]  target_level;
		logic [COUNT_W-1:0]  pulse_total;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]   reload_value;
		logic                running;
		logic                step_level;
		logic [PHASE_W-1:0]  phase;
		logic [LEVEL_W-1:0]  speed_level;
	} result_t;

endpackage

[src/str_ifs.sv]
// ----------------------------------------------------------------------------
// str_ifs: channel interfaces of the stepper trapezoid ramp unit
// Command channel, result channel and reload step write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface str_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [str_pkg::CMD_W-1:0]   command;
	logic [str_pkg::LEVEL_W-1:0] target_level;
	logic [str_pkg::COUNT_W-1:0] pulse_total;

	modport source (output valid, output command, output target_level,
		output pulse_total, input ready);
	modport sink (input valid, input command, input target_level,
		input pulse_total, output ready);
endinterface

interface str_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [str_pkg::STEP_W-1:0]  reload_value;
	logic                        running;
	logic                        step_level;
	logic [str_pkg::PHASE_W-1:0] phase;
	logic [str_pkg::LEVEL_W-1:0] speed_level;

	modport source (output valid, output reload_value, output running,
		output step_level, output phase, output speed_level, input ready);
	modport sink (input valid, input reload_value, input running,
		input step_level, input phase, input speed_level, output ready);
endinterface

interface str_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [str_pkg::STEP_W-1:0] reload_step;

	modport source (output valid, output reload_step, input ready);
	modport sink (input valid, input reload_step, output ready);
endinterface

[src/stepper_trapezoid_ramp_unit.sv]
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit: stepper pulse generator with trapezoidal ramp
// Takes start, stop, ramp tick and pulse requests and returns one result per
// request: the next timer reload, run flag, step pin, phase and speed level.
//
//   Channel  Dir  Payload
//   cmd      in   command, target_level, pulse_total
//   rsp      out  reload_value, running, step_level, phase, speed_level
//   cfg      in   reload_step (always ready)
//
// A request is registered on acceptance and its result is then registered
// in the result register; one request is taken per cycle unless rsp stalls.
// The rate is set by the single state update between the two registers.
// A stalled result holds the request register; cmd ready drops only then.
// Reset clears all ramp state and loads reload_step with 2500.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_unit (
	input  logic   clk,
	input  logic   arst_n,
	str_cmd_if.sink   cmd,
	str_rsp_if.source rsp,
	str_cfg_if.sink   cfg
);
	import str_pkg::*;

	logic               valid_s1;
	item_t              item_s1;
	logic               adv_s1;
	logic               rsp_valid_q;
	result_t            result_q;
	result_t            result_d;
	logic [STEP_W-1:0]  reload_step_q;

	// Reload step register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_step_q <= RELOAD_STEP_RST;
		end else if (cfg.valid) begin
			reload_step_q <= cfg.reload_step;
		end
	end

	// Request register moves on when the result register is free.
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.command      <= cmd_t'(cmd.command);
			item_s1.target_level <= cmd.target_level;
			item_s1.pulse_total  <= cmd.pulse_total;
		end
	end

	// Ramp state and event logic.
	str_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv_s1),
		.item        (item_s1),
		.reload_step (reload_step_q),
		.result      (result_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= result_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.reload_value = result_q.reload_value;
	assign rsp.running      = result_q.running;
	assign rsp.step_level   = result_q.step_level;
	assign rsp.phase        = result_q.phase;
	assign rsp.speed_level  = result_q.speed_level;

	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_valid_q)
		else $error("processed request left no result");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> valid_s1)
		else $error("accepted request not registered");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !cmd.ready)
		else $error("request taken while request register is stalled");

endmodule

[src/str_core.sv]
// ----------------------------------------------------------------------------
// str_core: ramp state and event logic
// Holds the run, phase, level and pulse counters, applies one registered
// request per cycle while fired, and gives the result of the updated state.
// ----------------------------------------------------------------------------
module str_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  str_pkg::item_t                item,
	input  logic [str_pkg::STEP_W-1:0]    reload_step,
	output str_pkg::result_t              result
);
	import str_pkg::*;

	phase_t               phase_q, phase_d;
	logic [LEVEL_W-1:0]   lvl_q, lvl_d;
	logic [LEVEL_W-1:0]   goal_q, goal_d;
	logic [COUNT_W-1:0]   done_q, done_d;
	logic [COUNT_W-1:0]   total_q, total_d;
	logic [COUNT_W-1:0]   decel_q, decel_d;
	logic                 pend_q, pend_d;
	logic                 run_q, run_d;
	logic                 pin_q, pin_d;
	logic [COUNT_W-1:0]   decel_cand;
	logic [COUNT_W-1:0]   done_inc;
	logic [LEVEL_W+STEP_W-1:0] prod;

	// Remaining pulses at a ramp end, and the count after this pulse.
	assign decel_cand = (total_q > done_q) ? (total_q - done_q) : '0;
	assign done_inc   = done_q + 1'b1;

	// Next state for the registered request.
	always_comb begin
		phase_d = phase_q;
		lvl_d   = lvl_q;
		goal_d  = goal_q;
		done_d  = done_q;
		total_d = total_q;
		decel_d = decel_q;
		pend_d  = pend_q;
		run_d   = run_q;
		pin_d   = pin_q;
		case (item.command)
			CMD_START: begin
				if (item.pulse_total == '0) begin
					run_d = 1'b0;
				end else if (!run_q) begin
					done_d  = '0;
					pend_d  = 1'b0;
					lvl_d   = '0;
					goal_d  = (item.target_level > LEVEL_MAX) ? LEVEL_MAX : item.target_level;
					total_d = item.pulse_total;
					phase_d = PH_ACCEL;
					decel_d = '0;
					run_d   = 1'b1;
				end
			end
			CMD_STOP: begin
				run_d = 1'b0;
			end
			CMD_TICK: begin
				pend_d = 1'b1;
			end
			CMD_PULSE: begin
				if (run_q) begin
					// A pending tick moves the level one step toward the goal, or enters cruise at it.
					if (phase_q != PH_CRUISE && pend_q) begin
						pend_d = 1'b0;
						if (phase_q == PH_DECEL) begin
							if (lvl_q > goal_q) begin
								lvl_d = lvl_q - 1'b1;
							end else begin
								phase_d = PH_CRUISE;
							end
						end else begin
							if (lvl_q < goal_q) begin
								lvl_d = lvl_q + 1'b1;
							end else begin
								phase_d = PH_CRUISE;
							end
						end
						if (phase_d == PH_CRUISE) begin
							decel_d = decel_cand;
						end
					end
					// Count the pulse, then check for the end and the decel point.
					done_d = done_inc;
					if (done_inc >= total_q) begin
						run_d   = 1'b0;
						phase_d = PH_CRUISE;
					end else if (phase_d == PH_CRUISE && done_inc >= decel_d) begin
						phase_d = PH_DECEL;
						goal_d  = '0;
					end
					pin_d = !pin_q;
				end
			end
			default: begin
			end
		endcase
	end

	// State registers advance once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CRUISE;
			lvl_q   <= '0;
			goal_q  <= '0;
			done_q  <= '0;
			total_q <= '0;
			decel_q <= '0;
			pend_q  <= 1'b0;
			run_q   <= 1'b0;
			pin_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			lvl_q   <= lvl_d;
			goal_q  <= goal_d;
			done_q  <= done_d;
			total_q <= total_d;
			decel_q <= decel_d;
			pend_q  <= pend_d;
			run_q   <= run_d;
			pin_q   <= pin_d;
		end
	end

	// Result fields come from the updated state.
	assign prod = lvl_d * reload_step;

	always_comb begin
		result.reload_value = prod[STEP_W-1:0];
		result.running      = run_d;
		result.step_level   = pin_d;
		result.phase        = phase_d;
		result.speed_level  = lvl_d;
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LEVEL_MAX && goal_q <= LEVEL_MAX)
		else $error("speed level or goal above the table");

	a_run_falls_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> $past(fire))
		else $error("run flag cleared without a request");

	a_pin_toggles_on_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.command == CMD_PULSE && run_q) |=> pin_q != $past(pin_q))
		else $error("step pin did not toggle on a pulse");

endmodule
